[design/ctwa_pkg.sv]
`timescale 1ns / 1ps

package ctwa_pkg;

  localparam int unsigned EndpointW  = 48;
  localparam int unsigned ClientIdxW = 3;
  localparam int unsigned MaskW      = 8;
  localparam int unsigned CountW     = 8;

  localparam logic [CountW-1:0] IdleMax      = 8'd255;
  localparam logic [CountW-1:0] TimeoutReset = 8'd30;

  typedef enum logic {
    CmdPacket = 1'b0,
    CmdTick   = 1'b1
  } cmd_e;

  typedef struct packed {
    cmd_e                 command;
    logic [EndpointW-1:0] client_endpoint;
  } item_t;

  typedef struct packed {
    logic [ClientIdxW-1:0] client_index;
    logic                  was_known;
    logic                  was_added;
    logic                  table_full;
    logic [MaskW-1:0]      dropped_mask;
  } result_t;

endpackage

[design/client_table_with_aging.sv]
`timescale 1ns / 1ps

// client table with idle aging
//
// command channel: an item (packet or tick) is taken on a rising edge with
// start_i high and busy_o low. busy_o stays low, so one item may be issued
// every cycle. each item yields exactly one result on result_o, flagged by
// done_o for a single cycle; the receiver cannot stall it
// result path: the accepted item passes the input register, then the
// lookup/aging logic into the result register
// throughput: 1 item per cycle, bounded by the combinational parallel
// compare and priority select across all slots
// configuration: cfg_valid_i/cfg_ready_o write the idle timeout from
// cfg_data_i; cfg_ready_o is always high. writes belong in idle periods
// reset (rst_ni low, asynchronous): all slots invalid, idle counts zero,
// timeout back to 30, pipeline empty. endpoint storage is not cleared, it
// is only ever read for valid slots
// slot numbers above 7 show up modulo 8 in client_index, and dropped_mask
// only covers slots 0 to 7

module client_table_with_aging
  import ctwa_pkg::*;
#(
  parameter int unsigned NUM_SLOTS = 8
) (
  input  logic                clk_i,
  input  logic                rst_ni,
  // command channel
  input  logic                start_i,
  output logic                busy_o,
  input  item_t               item_i,
  // result channel
  output logic                done_o,
  output result_t             result_o,
  // configuration write channel
  input  logic                cfg_valid_i,
  output logic                cfg_ready_o,
  input  logic [CountW-1:0]   cfg_data_i
);

  localparam int unsigned IdxW = (NUM_SLOTS > 1) ? $clog2(NUM_SLOTS) : 1;

  // transaction acceptance
  logic accept;

  // input register stage
  logic  req_valid_q;
  item_t req_q;

  // table state
  logic [NUM_SLOTS-1:0]                valid_q, valid_d;
  logic [NUM_SLOTS-1:0][CountW-1:0]    count_q, count_d;
  logic [NUM_SLOTS-1:0][EndpointW-1:0] ep_q;

  // timeout register
  logic [CountW-1:0] timeout_q;

  // lookup results
  logic            hit, free;
  logic [IdxW-1:0] hit_idx, free_idx;

  // result stage
  logic    done_q;
  result_t res_q, res_d;

  // packet write into a free slot
  logic do_add;

  // wide helpers for the modulo-8 index and low-8 mask
  logic [IdxW+ClientIdxW-1:0] idx_ext;
  logic [NUM_SLOTS+MaskW-1:0] drop_ext;
  logic [NUM_SLOTS-1:0]       drop_vec;

  assign busy_o      = 1'b0;
  assign accept      = start_i && !busy_o;
  assign cfg_ready_o = 1'b1;

  // timeout register, to be written only between transactions; the block does not enforce it
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      timeout_q <= TimeoutReset;
    end else if (cfg_valid_i && cfg_ready_o) begin
      timeout_q <= cfg_data_i;
    end
  end

  // input register: control part reset, payload not reset and loaded on accept
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      req_valid_q <= 1'b0;
    end else begin
      req_valid_q <= accept;
    end
  end

  always_ff @(posedge clk_i) begin
    if (accept) begin
      req_q <= item_i;
    end
  end

  // endpoint search across the table
  ctwa_match #(
    .NUM_SLOTS (NUM_SLOTS),
    .IdxW      (IdxW)
  ) u_match (
    .valid_i    (valid_q),
    .slot_ep_i  (ep_q),
    .endpoint_i (req_q.client_endpoint),
    .hit_o      (hit),
    .hit_idx_o  (hit_idx),
    .free_o     (free),
    .free_idx_o (free_idx)
  );

  // per-slot next state and the result word
  always_comb begin
    valid_d  = valid_q;
    count_d  = count_q;
    drop_vec = '0;
    do_add   = 1'b0;
    res_d    = '0;
    idx_ext  = '0;
    drop_ext = '0;
    if (req_valid_q) begin
      unique case (req_q.command)
        CmdTick: begin
          // every counter ages, even for empty slots; saturate at the top
          for (int i = 0; i < NUM_SLOTS; i++) begin
            if (count_q[i] != IdleMax) begin
              count_d[i] = count_q[i] + CountW'(1);
            end
            if (valid_q[i] && (count_d[i] > timeout_q)) begin
              valid_d[i]  = 1'b0;
              drop_vec[i] = 1'b1;
            end
          end
          drop_ext           = {{MaskW{1'b0}}, drop_vec};
          res_d.dropped_mask = drop_ext[MaskW-1:0];
        end
        CmdPacket: begin
          priority if (hit) begin
            count_d[hit_idx]   = '0;
            idx_ext            = {{ClientIdxW{1'b0}}, hit_idx};
            res_d.client_index = idx_ext[ClientIdxW-1:0];
            res_d.was_known    = 1'b1;
          end else if (free) begin
            do_add              = 1'b1;
            valid_d[free_idx]   = 1'b1;
            count_d[free_idx]   = '0;
            idx_ext             = {{ClientIdxW{1'b0}}, free_idx};
            res_d.client_index  = idx_ext[ClientIdxW-1:0];
            res_d.was_added     = 1'b1;
          end else begin
            // table full: no state change, index reads as zero
            res_d.table_full = 1'b1;
          end
        end
        default: begin
          res_d = '0;
        end
      endcase
    end
  end

  // table control state
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= '0;
      count_q <= '0;
    end else begin
      valid_q <= valid_d;
      count_q <= count_d;
    end
  end

  // endpoint storage, written only when a slot is claimed
  always_ff @(posedge clk_i) begin
    if (do_add) begin
      ep_q[free_idx] <= req_q.client_endpoint;
    end
  end

  // result register with one-cycle strobe
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      done_q <= 1'b0;
    end else begin
      done_q <= req_valid_q;
    end
  end

  always_ff @(posedge clk_i) begin
    if (req_valid_q) begin
      res_q <= res_d;
    end
  end

  assign done_o   = done_q;
  assign result_o = res_q;

endmodule

[design/ctwa_match.sv]
`timescale 1ns / 1ps

module ctwa_match
  import ctwa_pkg::*;
#(
  parameter int unsigned NUM_SLOTS = 8,
  parameter int unsigned IdxW      = 3
) (
  input  logic [NUM_SLOTS-1:0]                valid_i,
  input  logic [NUM_SLOTS-1:0][EndpointW-1:0] slot_ep_i,
  input  logic [EndpointW-1:0]                endpoint_i,
  output logic                                hit_o,
  output logic [IdxW-1:0]                     hit_idx_o,
  output logic                                free_o,
  output logic [IdxW-1:0]                     free_idx_o
);

  logic [NUM_SLOTS-1:0] hit_vec;

  // parallel compare against every valid slot
  always_comb begin
    for (int i = 0; i < NUM_SLOTS; i++) begin
      hit_vec[i] = valid_i[i] && (slot_ep_i[i] == endpoint_i);
    end
  end

  // lowest index wins for both searches
  always_comb begin
    hit_idx_o  = '0;
    free_idx_o = '0;
    for (int i = NUM_SLOTS - 1; i >= 0; i--) begin
      if (hit_vec[i]) begin
        hit_idx_o = IdxW'(i);
      end
      if (!valid_i[i]) begin
        free_idx_o = IdxW'(i);
      end
    end
  end

  assign hit_o  = |hit_vec;
  assign free_o = ~&valid_i;

endmodule

[design/ctwa_checker.sv]
`timescale 1ns / 1ps

module ctwa_checker
  import ctwa_pkg::*;
(
  input logic    clk_i,
  input logic    rst_ni,
  input logic    start_i,
  input logic    busy_o,
  input logic    done_o,
  input result_t result_o
);

  // every accepted transaction comes back on done_o, through the input and result registers
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    start_i && !busy_o |-> ##2 done_o)
    else $error("result missing two cycles after accept");

  // a packet result is at most one of hit, add and full
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    done_o |-> $onehot0({result_o.was_known, result_o.was_added, result_o.table_full}))
    else $error("packet outcome flags overlap");

  // drops only come from ticks, which carry no packet flags
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    done_o && (result_o.dropped_mask != '0) |->
      !result_o.was_known && !result_o.was_added && !result_o.table_full)
    else $error("dropped mask on a packet result");

  // a full table reports slot zero
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    done_o && result_o.table_full |-> (result_o.client_index == '0))
    else $error("index set on a full-table result");

endmodule

bind client_table_with_aging ctwa_checker u_ctwa_checker (
  .clk_i    (clk_i),
  .rst_ni   (rst_ni),
  .start_i  (start_i),
  .busy_o   (busy_o),
  .done_o   (done_o),
  .result_o (result_o)
);

[bench/tb_client_table_with_aging.sv]
`timescale 1ns / 1ps

module tb_client_table_with_aging;
  import ctwa_pkg::*;

  localparam int unsigned Slots      = 8;
  localparam int unsigned PoolSize   = 12;
  localparam int unsigned PhaseItems = 160;
  localparam int unsigned BurstTicks = 260;
  localparam int unsigned CycleLimit = 200000;

  // timeout settings walked by the random part, extremes included
  localparam int unsigned PlanLen = 8;
  localparam int unsigned RandomTimeout = 999;
  int unsigned timeout_plan [PlanLen] = '{30, 1, 254, 0, 255, RandomTimeout, 7, 100};

  // one row of the directed table: either a timeout write or an item
  typedef struct {
    bit                is_cfg;
    logic [CountW-1:0] cfg_value;
    item_t             item;
    bit                typed;
    result_t           want;
  } row_t;

  logic              clk_i = 1'b0;
  logic              rst_ni = 1'b0;
  logic              start_i = 1'b0;
  logic              busy_o;
  item_t             item_i = '0;
  logic              done_o;
  result_t           result_o;
  logic              cfg_valid_i = 1'b0;
  logic              cfg_ready_o;
  logic [CountW-1:0] cfg_data_i = '0;

  // typed expectation travels alongside the item it belongs to
  bit                typed_q = 1'b0;
  result_t           typed_want = '0;

  // model of the client table
  logic [EndpointW-1:0] slot_ep   [Slots];
  logic                 slot_live [Slots];
  logic [CountW-1:0]    slot_age  [Slots];
  logic [CountW-1:0]    timeout_model = TimeoutReset;

  result_t     expected_results [$];
  row_t        stim_rows [$];
  int unsigned mismatches = 0;
  int unsigned cycle_count = 0;
  int unsigned items_sent = 0;
  int unsigned n_known = 0, n_added = 0, n_full = 0, n_ticks = 0, n_drops = 0;
  int unsigned n_cfg = 0;

  client_table_with_aging #(
    .NUM_SLOTS (Slots)
  ) u_dut (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .start_i     (start_i),
    .busy_o      (busy_o),
    .item_i      (item_i),
    .done_o      (done_o),
    .result_o    (result_o),
    .cfg_valid_i (cfg_valid_i),
    .cfg_ready_o (cfg_ready_o),
    .cfg_data_i  (cfg_data_i)
  );

  // 4 ns clock
  always begin
    #2 clk_i = 1'b1;
    #2 clk_i = 1'b0;
  end

  // watchdog on total run length
  always @(posedge clk_i) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count > CycleLimit) begin
      $display("%0t: timeout after %0d cycles, %0d results outstanding", $time,
               cycle_count, expected_results.size());
      $display("Some tests failed");
      $finish;
    end
  end

  initial begin
    for (int i = 0; i < Slots; i++) begin
      slot_ep[i]   = '0;
      slot_live[i] = 1'b0;
      slot_age[i]  = '0;
    end
  end

  function automatic result_t mk_res(input int unsigned idx, input bit known,
                                     input bit added, input bit full,
                                     input int unsigned mask);
    result_t r;
    r.client_index = idx[ClientIdxW-1:0];
    r.was_known    = known;
    r.was_added    = added;
    r.table_full   = full;
    r.dropped_mask = mask[MaskW-1:0];
    return r;
  endfunction

  // applies one item to the model table and returns its result
  function automatic result_t apply_item(input item_t it);
    result_t r;
    int      hit;
    int      free_slot;
    r = '0;
    hit = -1;
    free_slot = -1;
    if (it.command == CmdTick) begin
      n_ticks++;
      // every slot ages, live or not, saturating at the top
      for (int i = 0; i < Slots; i++) begin
        if (slot_age[i] != IdleMax) slot_age[i] = slot_age[i] + 1'b1;
        if (slot_live[i] && slot_age[i] > timeout_model) begin
          slot_live[i] = 1'b0;
          n_drops++;
          if (i < MaskW) r.dropped_mask[i] = 1'b1;
        end
      end
    end else begin
      // lowest matching live slot wins, lowest free slot is taken on a miss
      for (int i = 0; i < Slots; i++) begin
        if (hit < 0 && slot_live[i] && slot_ep[i] == it.client_endpoint) hit = i;
        if (free_slot < 0 && !slot_live[i]) free_slot = i;
      end
      if (hit >= 0) begin
        slot_age[hit]  = '0;
        r.client_index = hit[ClientIdxW-1:0];
        r.was_known    = 1'b1;
        n_known++;
      end else if (free_slot >= 0) begin
        slot_ep[free_slot]   = it.client_endpoint;
        slot_live[free_slot] = 1'b1;
        slot_age[free_slot]  = '0;
        r.client_index       = free_slot[ClientIdxW-1:0];
        r.was_added          = 1'b1;
        n_added++;
      end else begin
        // full table: state left alone
        r.table_full = 1'b1;
        n_full++;
      end
    end
    return r;
  endfunction

  task automatic report_field(input string name, input logic [7:0] want,
                              input logic [7:0] got);
    if (want !== got) begin
      $display("%0t: %s mismatch, expected %0h actual %0h", $time, name, want, got);
      mismatches++;
    end
  endtask

  // scoreboard: results checked first, then timeout writes, then new items
  always @(posedge clk_i) begin : scoreboard
    result_t want;
    result_t pred;
    if (rst_ni) begin
      if (done_o) begin
        if (expected_results.size() == 0) begin
          $display("%0t: unexpected result, expected none actual %h", $time, result_o);
          mismatches++;
        end else begin
          want = expected_results.pop_front();
          report_field("client_index", 8'(want.client_index), 8'(result_o.client_index));
          report_field("was_known", 8'(want.was_known), 8'(result_o.was_known));
          report_field("was_added", 8'(want.was_added), 8'(result_o.was_added));
          report_field("table_full", 8'(want.table_full), 8'(result_o.table_full));
          report_field("dropped_mask", want.dropped_mask, result_o.dropped_mask);
        end
      end
      if (cfg_valid_i && cfg_ready_o) begin
        timeout_model = cfg_data_i;
        n_cfg++;
      end
      if (start_i && !busy_o) begin
        pred = apply_item(item_i);
        expected_results.push_back(typed_q ? typed_want : pred);
      end
    end
  end

  // sender idling: busy first third, heavier second third, none at the end
  function automatic int unsigned sender_idle_pct();
    if (items_sent < 520) return 38;
    if (items_sent < 1040) return 67;
    return 0;
  endfunction

  // start_i is only lowered inside a gap, so back-to-back items keep it high
  task automatic send_item(input item_t it, input bit typed, input result_t want);
    bit taken;
    while ($urandom_range(0, 99) < sender_idle_pct()) begin
      start_i <= 1'b0;
      @(posedge clk_i);
    end
    start_i    <= 1'b1;
    item_i     <= it;
    typed_q    <= typed;
    typed_want <= want;
    // busy_o only moves on a rising edge, so the falling edge shows what the next one sees
    do begin
      @(negedge clk_i);
      taken = !busy_o;
      @(posedge clk_i);
    end while (!taken);
    items_sent++;
  endtask

  // hold the sender off until every outstanding result has come back
  task automatic drain();
    start_i <= 1'b0;
    do @(negedge clk_i); while (expected_results.size() != 0);
    @(posedge clk_i);
  endtask

  task automatic write_timeout(input logic [CountW-1:0] value);
    bit taken;
    drain();
    // let the two pipeline stages empty out
    repeat (2) @(posedge clk_i);
    cfg_valid_i <= 1'b1;
    cfg_data_i  <= value;
    do begin
      @(negedge clk_i);
      taken = cfg_ready_o;
      @(posedge clk_i);
    end while (!taken);
    cfg_valid_i <= 1'b0;
  endtask

  task automatic add_row(input bit is_cfg, input logic [CountW-1:0] cfg_value,
                         input cmd_e cmd, input logic [EndpointW-1:0] ep,
                         input bit typed, input result_t want);
    row_t r;
    r.is_cfg                 = is_cfg;
    r.cfg_value              = cfg_value;
    r.item.command           = cmd;
    r.item.client_endpoint   = ep;
    r.typed                  = typed;
    r.want                   = want;
    stim_rows.push_back(r);
  endtask

  function automatic logic [EndpointW-1:0] random_endpoint();
    logic [63:0] raw;
    raw = {$urandom, $urandom};
    return raw[EndpointW-1:0];
  endfunction

  initial begin : stimulus
    logic [EndpointW-1:0] pool [PoolSize];
    logic [31:0]          shared_ip;
    logic [CountW-1:0]    tmo;
    item_t                it;
    int unsigned          tick_pct;
    int unsigned          roll;

    // directed table, typed expectations where obvious
    // fresh table: first endpoints land in the lowest slots
    add_row(0, 0, CmdPacket, 48'h0, 1, mk_res(0, 0, 1, 0, 0));
    add_row(0, 0, CmdPacket, 48'hFFFF_FFFF_FFFF, 1, mk_res(1, 0, 1, 0, 0));
    add_row(0, 0, CmdPacket, 48'h0, 1, mk_res(0, 1, 0, 0, 0));
    // tick well inside the reset timeout drops nothing
    add_row(0, 0, CmdTick, 48'h0, 1, mk_res(0, 0, 0, 0, 0));
    add_row(0, 0, CmdPacket, 48'hAAAA_AAAA_AAAA, 1, mk_res(2, 0, 1, 0, 0));
    add_row(0, 0, CmdPacket, 48'h5555_5555_5555, 1, mk_res(3, 0, 1, 0, 0));
    add_row(0, 0, CmdPacket, 48'hC0A8_0001_0050, 1, mk_res(4, 0, 1, 0, 0));
    // same address, different port is a different client
    add_row(0, 0, CmdPacket, 48'hC0A8_0001_0051, 1, mk_res(5, 0, 1, 0, 0));
    add_row(0, 0, CmdPacket, 48'h0000_0000_FFFF, 1, mk_res(6, 0, 1, 0, 0));
    add_row(0, 0, CmdPacket, 48'hFFFF_FFFF_0000, 1, mk_res(7, 0, 1, 0, 0));
    // full table: flag raised, index zero, nothing stored
    add_row(0, 0, CmdPacket, 48'h1234_5678_9ABC, 1, mk_res(0, 0, 0, 1, 0));
    add_row(0, 0, CmdPacket, 48'hFFFF_FFFF_FFFF, 1, mk_res(1, 1, 0, 0, 0));
    // zero timeout: every live slot goes on the next tick
    add_row(1, 8'd0, CmdPacket, 48'h0, 0, '0);
    add_row(0, 0, CmdTick, 48'hFFFF_FFFF_FFFF, 1, mk_res(0, 0, 0, 0, 8'hFF));
    add_row(0, 0, CmdPacket, 48'h0000_0000_0001, 1, mk_res(0, 0, 1, 0, 0));
    // top timeout: nothing can ever age out
    add_row(1, 8'd255, CmdPacket, 48'h0, 0, '0);
    add_row(0, 0, CmdTick, 48'h0, 0, '0);
    add_row(0, 0, CmdTick, 48'h0, 0, '0);
    add_row(0, 0, CmdPacket, 48'h0000_0000_0001, 0, '0);
    add_row(1, 8'd1, CmdPacket, 48'h0, 0, '0);
    add_row(0, 0, CmdTick, 48'h0, 0, '0);
    add_row(0, 0, CmdTick, 48'h0, 0, '0);
    add_row(1, 8'd254, CmdPacket, 48'h0, 0, '0);
    add_row(0, 0, CmdPacket, 48'h8000_0000_0000, 0, '0);
    add_row(0, 0, CmdPacket, 48'h0000_0000_0001, 0, '0);

    // reset held low from the start, then released on an edge
    repeat (6) @(posedge clk_i);
    rst_ni <= 1'b1;
    repeat (2) @(posedge clk_i);

    foreach (stim_rows[i]) begin
      if (stim_rows[i].is_cfg) write_timeout(stim_rows[i].cfg_value);
      else send_item(stim_rows[i].item, stim_rows[i].typed, stim_rows[i].want);
    end

    // random phases, one timeout setting each
    for (int p = 0; p < PlanLen; p++) begin
      if (timeout_plan[p] == RandomTimeout) tmo = CountW'($urandom_range(0, 255));
      else tmo = CountW'(timeout_plan[p]);
      write_timeout(tmo);

      // small endpoint pool: half share one address, more clients than slots
      shared_ip = $urandom;
      for (int k = 0; k < PoolSize; k++) begin
        pool[k] = random_endpoint();
        if (k < PoolSize / 2) pool[k][47:16] = shared_ip;
      end
      tick_pct = $urandom_range(5, 60);

      for (int n = 0; n < PhaseItems; n++) begin
        // long tick run so the widest timeout can expire and counters saturate
        if (timeout_plan[p] == 254 && n == 40) begin
          for (int b = 0; b < BurstTicks; b++) begin
            it.command         = CmdTick;
            it.client_endpoint = random_endpoint();
            send_item(it, 0, '0);
          end
        end
        // one pause mid-phase until the pipeline has drained
        if (n == PhaseItems / 2) drain();
        roll = $urandom_range(0, 99);
        if (roll < tick_pct) begin
          it.command         = CmdTick;
          it.client_endpoint = random_endpoint();
        end else if (roll < 95) begin
          it.command         = CmdPacket;
          it.client_endpoint = pool[$urandom_range(0, PoolSize - 1)];
        end else begin
          // stray endpoint, almost certainly a miss
          it.command         = CmdPacket;
          it.client_endpoint = random_endpoint();
        end
        send_item(it, 0, '0);
      end
    end

    // wait for the tail, then keep clocking so anything stray shows up
    drain();
    repeat (4) @(posedge clk_i);

    $display("run: %0d items over %0d timeout writes; packets %0d known, %0d added, %0d full",
             items_sent, n_cfg, n_known, n_added, n_full);
    $display("run: %0d ticks dropped %0d clients; %0d mismatches", n_ticks, n_drops,
             mismatches);
    if (mismatches == 0) begin
      $display("All tests passed");
    end else begin
      $display("Some tests failed");
    end
    $finish;
  end

endmodule

[filelist.f]
design/ctwa_pkg.sv
design/ctwa_match.sv
design/client_table_with_aging.sv
design/ctwa_checker.sv
bench/tb_client_table_with_aging.sv
